// ===== rtl/core/sliding_median_filter_top_defines.svh =====
// ----------------------------------------------------------------------------
// Sliding median filter assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MEDIAN_FILTER_TOP_DEFINES_SVH
`define SLIDING_MEDIAN_FILTER_TOP_DEFINES_SVH

// same-cycle implication
`define SMF_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/smf_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding median filter package
// Sample type and fixed field widths shared by the filter modules.
// ----------------------------------------------------------------------------
package smf_pkg;

    localparam int SAMPLE_W = 32;
    localparam int RADIUS_W = 4;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd1;

endpackage

// ===== rtl/core/smf_cell.sv =====
// ----------------------------------------------------------------------------
// Sliding median filter window cell
// Holds one window sample, shifts it to the next cell on each accepted item
// and ranks it against the active part of the window.
// ----------------------------------------------------------------------------
module smf_cell #(
    parameter int DEPTH = 17,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  smf_pkg::sample_t     din,
    input  logic [IDX_W-1:0]     position,
    input  smf_pkg::sample_t     win [DEPTH],
    input  logic [DEPTH-1:0]     active,
    output smf_pkg::sample_t     q,
    output logic [IDX_W-1:0]     rank
);
    import smf_pkg::*;

    sample_t          q_reg;
    sample_t          q_next;
    logic [DEPTH-1:0] below;

    always_comb
    begin
        q_next = shift ? din : q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    // ties break toward the newer position
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            below[j] = active[j] && (IDX_W'(j) != position) &&
                       ((win[j] < q_reg) ||
                        ((win[j] == q_reg) && (IDX_W'(j) < position)));
        end
    end

    assign q    = q_reg;
    assign rank = IDX_W'($countones(below));

endmodule

// ===== rtl/core/sliding_median_filter_top.sv =====
// ----------------------------------------------------------------------------
// Sliding median filter
// Streaming 1-D median filter of radius R over a window of 2R+1 samples,
// output delayed by R samples, edges passed through, tail flushed on last.
// ----------------------------------------------------------------------------
//  channel  | signals                          | handshake
//  ---------+----------------------------------+-----------------------
//  input    | sample_in, last_in               | in_valid / in_ready
//  output   | sample_out, last_out             | out_valid / out_ready
//  config   | cfg_data (radius)                | cfg_we, no wait
//
//  A last item yields up to MAX_RADIUS+1 results, one per cycle while the
//  output is not stalled; a new item is taken as the last pending result
//  is loaded. The median comes from per-cell ranks in the same cycle.
//  Reset is immediate, no clearing pass. A stalled output holds its result
//  and backs up the input while a result is pending.
// ----------------------------------------------------------------------------
`include "sliding_median_filter_top_defines.svh"

module sliding_median_filter_top #(
    parameter int MAX_RADIUS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  smf_pkg::sample_t              sample_in,
    input  logic                          last_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output smf_pkg::sample_t              sample_out,
    output logic                          last_out,
    input  logic                          cfg_we,
    input  logic [smf_pkg::RADIUS_W-1:0]  cfg_data
);
    import smf_pkg::*;

    localparam int DEPTH     = 2 * MAX_RADIUS + 1;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int COUNT_CAP = 2 * MAX_RADIUS;

    logic [RADIUS_W-1:0] radius_reg;
    logic [IDX_W-1:0]    r_eff;
    logic [IDX_W-1:0]    two_r;

    logic [IDX_W-1:0]    seen_reg,      seen_next;
    logic                main_pend_reg, main_pend_next;
    logic                main_med_reg,  main_med_next;
    logic                main_last_reg, main_last_next;
    logic                flush_pend_reg, flush_pend_next;
    logic [IDX_W-1:0]    flush_d_reg,   flush_d_next;

    logic                out_valid_reg, out_valid_next;
    sample_t             sample_out_reg, sample_out_next;
    logic                last_out_reg,  last_out_next;

    logic                accept;
    logic                busy;
    logic                load;
    logic                load_final;
    logic [IDX_W-1:0]    rd_idx;
    logic                res_last;
    sample_t             res_val;

    sample_t             win [DEPTH];
    logic [IDX_W-1:0]    rank [DEPTH];
    logic [DEPTH-1:0]    active;
    logic [DEPTH-1:0]    med_hit;
    logic [DEPTH-1:0]    sel;

    assign r_eff = (int'(radius_reg) > MAX_RADIUS) ? IDX_W'(MAX_RADIUS) : IDX_W'(radius_reg);
    assign two_r = IDX_W'(r_eff << 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            radius_reg <= cfg_data;
        end
    end

    // window chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sample_t cell_din;

        if (i == 0)
        begin : g_head
            assign cell_din = sample_in;
        end
        else
        begin : g_body
            assign cell_din = win[i-1];
        end

        assign active[i]  = (IDX_W'(i) <= two_r);
        assign med_hit[i] = active[i] && (rank[i] == r_eff);

        smf_cell #(
            .DEPTH (DEPTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (accept),
            .din      (cell_din),
            .position (IDX_W'(i)),
            .win      (win),
            .active   (active),
            .q        (win[i]),
            .rank     (rank[i])
        );
    end

    assign busy       = main_pend_reg || flush_pend_reg;
    assign load       = busy && (!out_valid_reg || out_ready);
    assign load_final = load && ((main_pend_reg && !flush_pend_reg) ||
                                 (!main_pend_reg && flush_pend_reg && (flush_d_reg == '0)));
    assign in_ready   = !busy || load_final;
    assign accept     = in_valid && in_ready;

    assign rd_idx   = main_pend_reg ? r_eff : flush_d_reg;
    assign res_last = main_pend_reg ? main_last_reg : (flush_d_reg == '0);

    always_comb
    begin
        res_val = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel[i] = (main_pend_reg && main_med_reg) ? med_hit[i] : (IDX_W'(i) == rd_idx);
            if (sel[i])
            begin
                res_val = res_val | win[i];
            end
        end
    end

    always_comb
    begin
        seen_next       = seen_reg;
        main_pend_next  = main_pend_reg;
        main_med_next   = main_med_reg;
        main_last_next  = main_last_reg;
        flush_pend_next = flush_pend_reg;
        flush_d_next    = flush_d_reg;

        // advance the pending run
        if (load)
        begin
            if (main_pend_reg)
            begin
                main_pend_next = 1'b0;
            end
            else if (flush_d_reg == '0)
            begin
                flush_pend_next = 1'b0;
            end
            else
            begin
                flush_d_next = flush_d_reg - 1'b1;
            end
        end

        // start the run of a new item
        if (accept)
        begin
            main_pend_next  = (seen_reg >= r_eff);
            main_med_next   = (seen_reg >= two_r);
            main_last_next  = last_in && (r_eff == '0);
            flush_pend_next = last_in && ((seen_reg < r_eff) || (r_eff != '0));
            flush_d_next    = (seen_reg >= r_eff) ? (r_eff - 1'b1) : seen_reg;
            if (last_in)
            begin
                seen_next = '0;
            end
            else if (int'(seen_reg) < COUNT_CAP)
            begin
                seen_next = seen_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;
        last_out_next   = last_out_reg;
        if (load)
        begin
            out_valid_next  = 1'b1;
            sample_out_next = res_val;
            last_out_next   = res_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= '0;
            main_pend_reg  <= 1'b0;
            main_med_reg   <= 1'b0;
            main_last_reg  <= 1'b0;
            flush_pend_reg <= 1'b0;
            flush_d_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            seen_reg       <= seen_next;
            main_pend_reg  <= main_pend_next;
            main_med_reg   <= main_med_next;
            main_last_reg  <= main_last_next;
            flush_pend_reg <= flush_pend_next;
            flush_d_reg    <= flush_d_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_out_reg <= sample_out_next;
        last_out_reg   <= last_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign last_out   = last_out_reg;

    `SMF_ASSERT_IMPLY(a_accept_when_drained, accept, (!busy || load_final), "item taken with results pending")
    `SMF_ASSERT_IMPLY(a_median_onehot, (load && main_pend_reg && main_med_reg), $onehot(med_hit), "median select not one-hot")
    `SMF_ASSERT_IMPLY(a_flush_bound, flush_pend_reg, (int'(flush_d_reg) < MAX_RADIUS), "flush index out of range")
    `SMF_ASSERT_IMPLY(a_last_is_final, (load && res_last), load_final, "last flag before end of run")
    `SMF_ASSERT_NEXT(a_count_clear, (accept && last_in), (seen_reg == '0), "count not cleared after last item")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding median filter testbench
// Streams signed signals of many lengths through the filter under several
// radius settings. A local model predicts the delayed median and the flushed
// tail for every item, and each output item is checked against it in order.
// Both handshakes stall at random, and one long output hold backs up the input.
// ----------------------------------------------------------------------------
module testbench;
    import smf_pkg::*;

    localparam int MAX_RADIUS  = 8;
    localparam int WIN_DEPTH   = 2 * MAX_RADIUS + 1;
    localparam int COUNT_CAP   = 2 * MAX_RADIUS;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 24;

    typedef struct packed {
        sample_t sample;
        logic    last;
    } filtered_item_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    sample_t             sample_in;
    logic                last_in;
    logic                out_valid;
    logic                out_ready;
    sample_t             sample_out;
    logic                last_out;
    logic                cfg_we;
    logic [RADIUS_W-1:0] cfg_data;

    sample_t             window_q [0:WIN_DEPTH-1];
    int                  seen_q;
    logic [RADIUS_W-1:0] radius_q;

    filtered_item_t      expected_outputs [$];

    int error_count;
    int items_sent;
    int signals_sent;
    int results_checked;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int stall_cycles;

    sliding_median_filter_top #(
        .MAX_RADIUS (MAX_RADIUS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .last_in    (last_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .last_out   (last_out),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic sample_t window_median(int n);
        sample_t sorted [0:WIN_DEPTH-1];
        sample_t key;
        int      i;
        int      j;
        for (i = 0; i < n; i++)
        begin
            key = window_q[i];
            j = i;
            while (j > 0 && sorted[j-1] > key)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        return sorted[n / 2];
    endfunction

    task automatic append_expected(input filtered_item_t item);
        expected_outputs.insert(expected_outputs.size(), item);
    endtask

    task automatic predict_filter_outputs(input sample_t x, input logic last);
        int             r;
        int             n;
        int             d;
        filtered_item_t item;
        r = (radius_q > MAX_RADIUS) ? MAX_RADIUS : int'(radius_q);
        n = seen_q;
        for (int i = WIN_DEPTH - 1; i > 0; i--)
            window_q[i] = window_q[i-1];
        window_q[0] = x;
        if (n >= r)
        begin
            item.sample = (n >= 2 * r) ? window_median(2 * r + 1) : window_q[r];
            item.last   = last && (r == 0);
            append_expected(item);
        end
        if (last)
        begin
            d = (n >= r) ? r - 1 : n;
            for (; d >= 0; d--)
            begin
                item.sample = window_q[d];
                item.last   = (d == 0);
                append_expected(item);
            end
            seen_q = 0;
        end
        else if (seen_q < COUNT_CAP)
        begin
            seen_q++;
        end
    endtask

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return sample_t'($urandom);
            4, 5, 6:    return sample_t'(int'($urandom_range(0, 20)) - 10);
            7:          return 32'sh7fffffff;
            8:          return 32'sh80000000;
            default:    return sample_t'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic send_sample(input sample_t x, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= x;
        last_in   <= last;
        do
            @(posedge clk);
        while (!in_ready);
        predict_filter_outputs(x, last);
        items_sent++;
        if (last)
            signals_sent++;
    endtask

    task automatic send_signal(input int length);
        for (int i = 0; i < length; i++)
            send_sample(random_sample(), i == length - 1);
    endtask

    task automatic send_signal_open(input int length);
        for (int i = 0; i < length; i++)
            send_sample(random_sample(), 1'b0);
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_radius(input logic [RADIUS_W-1:0] value);
        drain_outputs();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        radius_q = value;
        cfg_we   <= 1'b0;
    endtask

    task automatic test_reset_radius_extremes();
        send_sample(32'sh7fffffff, 1'b0);
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sh00000000, 1'b0);
        send_sample(32'shffffffff, 1'b0);
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sh7fffffff, 1'b1);
        send_sample(32'sh12345678, 1'b1);
    endtask

    task automatic test_radius_zero();
        set_radius(4'd0);
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sh7fffffff, 1'b0);
        send_sample(-32'sd5, 1'b1);
    endtask

    task automatic test_short_signal_max_radius();
        set_radius(4'd8);
        send_signal(5);
        set_radius(4'd15);
        send_signal(4);
    endtask

    task automatic test_radius_change_midsignal();
        set_radius(4'd1);
        send_signal_open(4);
        set_radius(4'd3);
        send_sample(random_sample(), 1'b0);
        send_sample(random_sample(), 1'b1);
        set_radius(4'd3);
        send_signal_open(3);
        set_radius(4'd0);
        send_sample(random_sample(), 1'b1);
    endtask

    task automatic test_long_signal();
        set_radius(4'd8);
        send_signal(40);
    endtask

    task automatic test_output_backpressure();
        set_radius(4'd2);
        send_idle_pct = 0;
        hold_cycles   = 120;
        send_signal(30);
        send_idle_pct = 29;
    endtask

    task automatic test_random_signals();
        int r;
        int stop_at;
        stop_at = items_sent + 100;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 5) == 0)
                set_radius(4'($urandom_range(9, 15)));
            else
                set_radius(4'($urandom_range(0, 8)));
            r = (radius_q > MAX_RADIUS) ? MAX_RADIUS : int'(radius_q);
            if ($urandom_range(0, 3) == 0)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                send_idle_pct = 29;
                recv_idle_pct = 29;
            end
            repeat (3)
                send_signal($urandom_range(1, 2 * r + 6));
        end
        send_idle_pct = 29;
        recv_idle_pct = 29;
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        filtered_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_outputs.size() == 0)
            begin
                $error("unexpected output item: sample_out %0d last_out %0b",
                       sample_out, last_out);
                error_count++;
            end
            else
            begin
                want = expected_outputs.pop_front();
                results_checked++;
                if (sample_out !== want.sample)
                begin
                    $error("sample_out mismatch: expected %0d, actual %0d",
                           want.sample, sample_out);
                    error_count++;
                end
                if (last_out !== want.last)
                begin
                    $error("last_out mismatch: expected %0b, actual %0b",
                           want.last, last_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        sample_in       = '0;
        last_in         = 1'b0;
        out_ready       = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        error_count     = 0;
        items_sent      = 0;
        signals_sent    = 0;
        results_checked = 0;
        send_idle_pct   = 29;
        recv_idle_pct   = 29;
        hold_cycles     = 0;
        stall_cycles    = 0;
        for (int i = 0; i < WIN_DEPTH; i++)
            window_q[i] = '0;
        seen_q   = 0;
        radius_q = RADIUS_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_radius_extremes();
        test_radius_zero();
        test_short_signal_max_radius();
        test_radius_change_midsignal();
        test_long_signal();
        test_output_backpressure();
        test_random_signals();

        drain_outputs();
        if (expected_outputs.size() != 0)
        begin
            $error("%0d expected output items never arrived", expected_outputs.size());
            error_count++;
        end
        $display("Sent %0d items in %0d signals, checked %0d filtered items",
                 items_sent, signals_sent, results_checked);
        $display("Radius 0 through 15, short and long signals, random stalls, long output hold");
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
